// ----- rtl/pce_pkg.sv -----
// ----------------------------------------------------------------------------
// pce_pkg
// shared types, register codes and weight constants for the color effect block
// ----------------------------------------------------------------------------
package pce_pkg;

  localparam int unsigned COEF_FRAC_BITS_DEF = 16;
  localparam int unsigned CHAN_W             = 8;
  localparam int unsigned CFG_IDX_W          = 2;
  localparam int unsigned CFG_DATA_W         = 8;
  localparam int unsigned MODE_W             = 3;

  // weights as decimal fractions: numerator over denominator
  localparam int unsigned GREY_DEN    = 10000;
  localparam int unsigned GREY_R_NUM  = 2105;
  localparam int unsigned GREY_G_NUM  = 7152;
  localparam int unsigned GREY_B_NUM  = 722;

  localparam int unsigned SEP_DEN     = 1000;
  localparam int unsigned SEP_RR_NUM  = 393;
  localparam int unsigned SEP_RG_NUM  = 769;
  localparam int unsigned SEP_RB_NUM  = 189;
  localparam int unsigned SEP_GR_NUM  = 349;
  localparam int unsigned SEP_GG_NUM  = 686;
  localparam int unsigned SEP_GB_NUM  = 168;
  localparam int unsigned SEP_BR_NUM  = 272;
  localparam int unsigned SEP_BG_NUM  = 534;
  localparam int unsigned SEP_BB_NUM  = 131;

  typedef enum logic [MODE_W-1:0] {
    MODE_PASS   = 3'd0,
    MODE_GREY   = 3'd1,
    MODE_SEPIA  = 3'd2,
    MODE_ADD    = 3'd3,
    MODE_REMOVE = 3'd4
  } effect_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_RED   = 2'd1,
    CFG_GREEN = 2'd2,
    CFG_BLUE  = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAN_W-1:0] red_level;
    logic [CHAN_W-1:0] green_level;
    logic [CHAN_W-1:0] blue_level;
  } cfg_t;

endpackage

// ----- rtl/pce_effect.sv -----
// ----------------------------------------------------------------------------
// pce_effect
// per-pixel effect datapath: pass-through, greyscale, sepia matrix, saturating add/remove
// ----------------------------------------------------------------------------
module pce_effect #(
  parameter int unsigned COEF_FRAC_BITS = pce_pkg::COEF_FRAC_BITS_DEF
) (
  input  pce_pkg::pixel_t pix_i,
  input  pce_pkg::cfg_t   cfg_i,
  output pce_pkg::pixel_t pix_o
);
  import pce_pkg::*;

  localparam int unsigned F  = COEF_FRAC_BITS;
  localparam int unsigned PW = F + CHAN_W;
  localparam int unsigned SW = F + CHAN_W + 2;
  localparam int unsigned YW = CHAN_W + 2;

  // round to nearest, halves up
  function automatic logic [63:0] grey_coef(input int unsigned num);
    grey_coef = ((64'(num) << F) + 64'(GREY_DEN / 2)) / 64'(GREY_DEN);
  endfunction

  function automatic logic [63:0] sep_coef(input int unsigned num);
    sep_coef = ((64'(num) << F) + 64'(SEP_DEN / 2)) / 64'(SEP_DEN);
  endfunction

  localparam logic [63:0] GWR = grey_coef(GREY_R_NUM);
  localparam logic [63:0] GWG = grey_coef(GREY_G_NUM);
  localparam logic [63:0] GWB = grey_coef(GREY_B_NUM);
  localparam logic [63:0] SRR = sep_coef(SEP_RR_NUM);
  localparam logic [63:0] SRG = sep_coef(SEP_RG_NUM);
  localparam logic [63:0] SRB = sep_coef(SEP_RB_NUM);
  localparam logic [63:0] SGR = sep_coef(SEP_GR_NUM);
  localparam logic [63:0] SGG = sep_coef(SEP_GG_NUM);
  localparam logic [63:0] SGB = sep_coef(SEP_GB_NUM);
  localparam logic [63:0] SBR = sep_coef(SEP_BR_NUM);
  localparam logic [63:0] SBG = sep_coef(SEP_BG_NUM);
  localparam logic [63:0] SBB = sep_coef(SEP_BB_NUM);

  localparam logic [F-1:0] W_GR = GWR[F-1:0];
  localparam logic [F-1:0] W_GG = GWG[F-1:0];
  localparam logic [F-1:0] W_GB = GWB[F-1:0];
  localparam logic [F-1:0] W_RR = SRR[F-1:0];
  localparam logic [F-1:0] W_RG = SRG[F-1:0];
  localparam logic [F-1:0] W_RB = SRB[F-1:0];
  localparam logic [F-1:0] W_NR = SGR[F-1:0];
  localparam logic [F-1:0] W_NG = SGG[F-1:0];
  localparam logic [F-1:0] W_NB = SGB[F-1:0];
  localparam logic [F-1:0] W_BR = SBR[F-1:0];
  localparam logic [F-1:0] W_BG = SBG[F-1:0];
  localparam logic [F-1:0] W_BB = SBB[F-1:0];

  logic [PW-1:0]     grey_r_p, grey_g_p, grey_b_p;
  logic [YW-1:0]     grey_sum;
  logic [CHAN_W-1:0] grey_val;
  logic [SW-1:0]     sep_r_sum, sep_g_sum, sep_b_sum;
  logic [YW-1:0]     sep_r_y, sep_g_y, sep_b_y;
  pixel_t            sepia, added, removed;
  logic [CHAN_W:0]   add_r, add_g, add_b;

  function automatic logic [CHAN_W-1:0] sat_y(input logic [YW-1:0] y);
    sat_y = (y > YW'({CHAN_W{1'b1}})) ? {CHAN_W{1'b1}} : y[CHAN_W-1:0];
  endfunction

  function automatic logic [SW-1:0] mac3(input logic [F-1:0] cr, input logic [F-1:0] cg,
                                         input logic [F-1:0] cb, input pixel_t p);
    mac3 = SW'(PW'(p.red) * PW'(cr)) + SW'(PW'(p.green) * PW'(cg))
         + SW'(PW'(p.blue) * PW'(cb));
  endfunction

  always_comb begin
    // greyscale floors each product before the sum
    grey_r_p = PW'(pix_i.red)   * PW'(W_GR);
    grey_g_p = PW'(pix_i.green) * PW'(W_GG);
    grey_b_p = PW'(pix_i.blue)  * PW'(W_GB);
    grey_sum = YW'(grey_r_p >> F) + YW'(grey_g_p >> F) + YW'(grey_b_p >> F);
    grey_val = sat_y(grey_sum);

    // sepia floors the sum of each row
    sep_r_sum = mac3(W_RR, W_RG, W_RB, pix_i);
    sep_g_sum = mac3(W_NR, W_NG, W_NB, pix_i);
    sep_b_sum = mac3(W_BR, W_BG, W_BB, pix_i);
    sep_r_y   = YW'(sep_r_sum >> F);
    sep_g_y   = YW'(sep_g_sum >> F);
    sep_b_y   = YW'(sep_b_sum >> F);
    sepia.red   = sat_y(sep_r_y);
    sepia.green = sat_y(sep_g_y);
    sepia.blue  = sat_y(sep_b_y);

    add_r = {1'b0, pix_i.red}   + {1'b0, cfg_i.red_level};
    add_g = {1'b0, pix_i.green} + {1'b0, cfg_i.green_level};
    add_b = {1'b0, pix_i.blue}  + {1'b0, cfg_i.blue_level};
    added.red   = add_r[CHAN_W] ? {CHAN_W{1'b1}} : add_r[CHAN_W-1:0];
    added.green = add_g[CHAN_W] ? {CHAN_W{1'b1}} : add_g[CHAN_W-1:0];
    added.blue  = add_b[CHAN_W] ? {CHAN_W{1'b1}} : add_b[CHAN_W-1:0];

    removed.red   = (pix_i.red > cfg_i.red_level) ? pix_i.red - cfg_i.red_level : '0;
    removed.green = (pix_i.green > cfg_i.green_level) ?
                    pix_i.green - cfg_i.green_level : '0;
    removed.blue  = (pix_i.blue > cfg_i.blue_level) ? pix_i.blue - cfg_i.blue_level : '0;

    case (cfg_i.mode)
      MODE_GREY:   pix_o = '{red: grey_val, green: grey_val, blue: grey_val};
      MODE_SEPIA:  pix_o = sepia;
      MODE_ADD:    pix_o = added;
      MODE_REMOVE: pix_o = removed;
      default:     pix_o = pix_i;
    endcase
  end

endmodule

// ----- rtl/pixel_color_effect.sv -----
// ----------------------------------------------------------------------------
// pixel_color_effect
// color effect on a stream of 8-bit rgb pixels, effect chosen by register
// ----------------------------------------------------------------------------
// path: an accepted pixel is held in the input register, passes the effect logic and
// is captured in the output register, from which the result is handed over
// throughput: 1 pixel per cycle; the input register feeds the effect logic and the
// output register, both advance whenever the output register is free or drained
// reset: effect_mode and the three levels clear to 0, both stages empty
// ----------------------------------------------------------------------------
module pixel_color_effect #(
  parameter int unsigned COEF_FRAC_BITS = pce_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pce_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pce_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [pce_pkg::CHAN_W-1:0]       red_in_i,
  input  logic [pce_pkg::CHAN_W-1:0]       green_in_i,
  input  logic [pce_pkg::CHAN_W-1:0]       blue_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [pce_pkg::CHAN_W-1:0]       red_out_o,
  output logic [pce_pkg::CHAN_W-1:0]       green_out_o,
  output logic [pce_pkg::CHAN_W-1:0]       blue_out_o
);
  import pce_pkg::*;

  cfg_t   cfg_q;
  logic   s1_valid_q, s1_valid_d;
  pixel_t s1_pix_q;
  logic   out_valid_q, out_valid_d;
  pixel_t out_pix_q;
  pixel_t fx_pix;
  logic   out_ready;
  logic   in_accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MODE:  cfg_q.mode        <= cfg_data_i[MODE_W-1:0];
        CFG_RED:   cfg_q.red_level   <= cfg_data_i[CHAN_W-1:0];
        CFG_GREEN: cfg_q.green_level <= cfg_data_i[CHAN_W-1:0];
        CFG_BLUE:  cfg_q.blue_level  <= cfg_data_i[CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // output register frees up when empty or drained this cycle
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !out_ready);
  assign out_valid_d = out_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q <= '{red: red_in_i, green: green_in_i, blue: blue_in_i};
    end
    if (out_ready && s1_valid_q) begin
      out_pix_q <= fx_pix;
    end
  end

  pce_effect #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_effect (
    .pix_i(s1_pix_q),
    .cfg_i(cfg_q),
    .pix_o(fx_pix)
  );

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_pix_q.red;
  assign green_out_o = out_pix_q.green;
  assign blue_out_o  = out_pix_q.blue;

  // stall only when an item sits in the input register behind a full output
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked item");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted item lost from input register");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_ready) |=> out_valid_o)
    else $error("item moved to output but output not valid");

  a_blocked_item_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_ready) |=> (s1_valid_q && $stable(s1_pix_q)))
    else $error("blocked item changed in input register");

endmodule
